### rtl/fsnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsnd_pkg
// Shared constants, result beat type and byte mapping helpers for the
// short-name decoder.
// ----------------------------------------------------------------------------
package fsnd_pkg;

  localparam int BASE_LEN_DEF   = 8;
  localparam int EXT_LEN_DEF    = 3;
  localparam int JOB_DEPTH_DEF  = 2;
  localparam int OUT_DEPTH_DEF  = 2;

  localparam logic [7:0] PAD_BYTE      = 8'h20;
  localparam logic [7:0] DEL_MARK      = 8'hE5;
  localparam logic [7:0] STANDIN_BYTE  = 8'h05;
  localparam logic [7:0] PRINT_LO      = 8'h20;
  localparam logic [7:0] PRINT_HI      = 8'h7E;
  localparam logic [7:0] SLASH_CHAR    = 8'h2F;
  localparam logic [7:0] PCT_CHAR      = 8'h25;
  localparam logic [7:0] DOT_CHAR      = 8'h2E;
  localparam logic [7:0] UPPER_A       = 8'h41;
  localparam logic [7:0] UPPER_Z       = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;
  localparam logic [7:0] LOST_CHAR_RST = 8'h5F;

  localparam int LC_BASE_BIT = 3;
  localparam int LC_EXT_BIT  = 4;

  // escape sequence positions
  localparam logic [1:0] ESC_PCT = 2'd0;
  localparam logic [1:0] ESC_HI  = 2'd1;
  localparam logic [1:0] ESC_LO  = 2'd2;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       has_byte;
    logic       last;
    logic       lossless;
  } out_item_t;

  typedef struct packed {
    logic       esc;
    logic [7:0] byte_val;
  } tok_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h41 + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

  // escape flag plus the byte to emit (raw byte when escaped)
  function automatic tok_t map_byte(input logic [7:0] b, input logic lower);
    tok_t t;
    logic pass;
    pass = (b >= PRINT_LO) && (b <= PRINT_HI) && (b != SLASH_CHAR) && (b != PCT_CHAR);
    t.esc = !pass;
    t.byte_val = b;
    if (pass && lower && (b >= UPPER_A) && (b <= UPPER_Z)) begin
      t.byte_val = b + CASE_OFFSET;
    end
    return t;
  endfunction

endpackage

### rtl/fsnd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsnd_fifo
// Small synchronous queue with full/empty flags, used between the front and
// back ends and on the result side.
// ----------------------------------------------------------------------------
module fsnd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/fsnd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsnd_front
// Classifies one directory name: trims padding, applies the deleted and
// stand-in rules, maps every byte to a token and flags escapes up front.
// ----------------------------------------------------------------------------
module fsnd_front
  import fsnd_pkg::*;
#(
  parameter int BASE_LEN = BASE_LEN_DEF,
  parameter int EXT_LEN  = EXT_LEN_DEF,
  parameter int NTOK     = BASE_LEN + EXT_LEN + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  input  logic [63:0]     base_bytes,
  input  logic [23:0]     ext_bytes,
  input  logic [7:0]      case_flags,
  input  logic            deleted,
  output tok_t [NTOK-1:0] job_tok,
  output logic [NTOK-1:0] job_mask,
  output logic            job_lossless
);

  logic [7:0]          lost_char_r;
  logic [7:0]          base_b [BASE_LEN];
  logic [7:0]          ext_b  [EXT_LEN];
  logic [BASE_LEN-1:0] bvld;
  logic [EXT_LEN-1:0]  evld;
  logic                lc_base, lc_ext;
  logic [7:0]          first_b;
  logic [NTOK-1:0]     esc_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_char_r <= LOST_CHAR_RST;
    end else if (cfg_we) begin
      lost_char_r <= cfg_data;
    end
  end

  assign lc_base = case_flags[LC_BASE_BIT];
  assign lc_ext  = case_flags[LC_EXT_BIT];

  always_comb begin
    for (int i = 0; i < BASE_LEN; i++) begin
      base_b[i] = base_bytes[8*i +: 8];
    end
    for (int i = 0; i < EXT_LEN; i++) begin
      ext_b[i] = ext_bytes[8*i +: 8];
    end
    // a byte is kept if it or any later byte of its half is not padding
    bvld[BASE_LEN-1] = (base_b[BASE_LEN-1] != PAD_BYTE);
    for (int i = BASE_LEN - 2; i >= 0; i--) begin
      bvld[i] = bvld[i+1] || (base_b[i] != PAD_BYTE);
    end
    evld[EXT_LEN-1] = (ext_b[EXT_LEN-1] != PAD_BYTE);
    for (int i = EXT_LEN - 2; i >= 0; i--) begin
      evld[i] = evld[i+1] || (ext_b[i] != PAD_BYTE);
    end
  end

  assign first_b = (base_b[0] == STANDIN_BYTE) ? DEL_MARK : base_b[0];

  always_comb begin
    for (int i = 0; i < BASE_LEN; i++) begin
      if (i == 0) begin
        if (deleted) begin
          job_tok[i].esc      = 1'b0;
          job_tok[i].byte_val = lost_char_r;
        end else begin
          job_tok[i] = map_byte(first_b, lc_base);
        end
      end else begin
        job_tok[i] = map_byte(base_b[i], lc_base);
      end
      job_mask[i] = bvld[i];
    end
    job_tok[BASE_LEN].esc      = 1'b0;
    job_tok[BASE_LEN].byte_val = DOT_CHAR;
    job_mask[BASE_LEN]         = evld[0];
    for (int i = 0; i < EXT_LEN; i++) begin
      job_tok[BASE_LEN+1+i] = map_byte(ext_b[i], lc_ext);
      job_mask[BASE_LEN+1+i] = evld[i];
    end
    for (int i = 0; i < NTOK; i++) begin
      esc_vec[i] = job_tok[i].esc;
    end
  end

  assign job_lossless = !(deleted && bvld[0]) && ((esc_vec & job_mask) == '0);

endmodule

### rtl/fsnd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsnd_back
// Walks the tokens of the oldest queued name and, unless item_full, emits
// one byte beat per cycle, expanding an escape to '%' and two hex digits.
// ----------------------------------------------------------------------------
module fsnd_back
  import fsnd_pkg::*;
#(
  parameter int NTOK = BASE_LEN_DEF + EXT_LEN_DEF + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  tok_t [NTOK-1:0] job_tok,
  input  logic [NTOK-1:0] job_mask,
  input  logic            job_lossless,
  output logic            job_pop,
  input  logic            item_full,
  output logic            item_push,
  output out_item_t       item
);

  logic [NTOK-1:0] done_r, done_nxt;
  logic [1:0]      sub_r, sub_nxt;
  logic [NTOK-1:0] rem, cur_oh;
  logic            empty_job, tok_end, final_beat;
  tok_t            cur;

  assign rem       = job_mask & ~done_r;
  assign cur_oh    = rem & (~rem + 1'b1);
  assign empty_job = (job_mask == '0);

  always_comb begin
    cur = '0;
    for (int i = 0; i < NTOK; i++) begin
      if (cur_oh[i]) begin
        cur = job_tok[i];
      end
    end
  end

  assign tok_end    = !cur.esc || (sub_r == ESC_LO);
  assign final_beat = empty_job || (tok_end && ((rem & ~cur_oh) == '0));
  assign item_push  = job_valid && !item_full;
  assign job_pop    = item_push && final_beat;

  always_comb begin
    item.has_byte = !empty_job;
    item.last     = final_beat;
    item.lossless = final_beat && job_lossless;
    if (empty_job) begin
      item.byte_val = 8'h00;
    end else if (!cur.esc) begin
      item.byte_val = cur.byte_val;
    end else begin
      case (sub_r)
        ESC_PCT: item.byte_val = PCT_CHAR;
        ESC_HI:  item.byte_val = hex_digit(cur.byte_val[7:4]);
        default: item.byte_val = hex_digit(cur.byte_val[3:0]);
      endcase
    end
  end

  always_comb begin
    done_nxt = done_r;
    sub_nxt  = sub_r;
    if (item_push) begin
      if (final_beat) begin
        done_nxt = '0;
        sub_nxt  = ESC_PCT;
      end else if (tok_end) begin
        done_nxt = done_r | cur_oh;
        sub_nxt  = ESC_PCT;
      end else begin
        sub_nxt = sub_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      sub_r  <= ESC_PCT;
    end else begin
      done_r <= done_nxt;
      sub_r  <= sub_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r != 2'd3)
    else $error("escape position out of range");

  a_sub_in_escape: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_r != ESC_PCT) |-> (job_valid && cur.esc))
    else $error("mid-escape without an escaped token");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (item_push && item.last))
    else $error("name released without its last beat");

  a_done_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (done_r == '0 && sub_r == ESC_PCT))
    else $error("token walk not restarted after a name");
`endif

endmodule

### rtl/fat_short_name_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_short_name_decoder
// Decodes an 8.3 directory short name into a stream of name bytes.
// ----------------------------------------------------------------------------
// The decoder emits one result beat per clock while the result queue has
// room; a name yields as many beats as it has output bytes (1 for a blank
// name, up to 34 when every byte is escaped; three per escaped byte, one per
// plain byte and one for the dot). The back-end token walker sets that rate:
// it drives one byte per cycle into the result queue unless that is full.
// A name queue between the classifier and the walker lets new names be
// taken while the previous one is still streaming, so names follow each
// other with no idle cycle; each beat is registered in the result queue.
module fat_short_name_decoder
  import fsnd_pkg::*;
#(
  parameter int BASE_LEN  = BASE_LEN_DEF,
  parameter int EXT_LEN   = EXT_LEN_DEF,
  parameter int JOB_DEPTH = JOB_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_base_bytes,
  input  logic [23:0] in_ext_bytes,
  input  logic [7:0]  in_case_flags,
  input  logic        in_deleted,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_last,
  output logic        out_lossless
);

  localparam int NTOK = BASE_LEN + EXT_LEN + 1;
  localparam int JW   = NTOK * $bits(tok_t) + NTOK + 1;
  localparam int IW   = $bits(out_item_t);

  tok_t [NTOK-1:0] f_tok, b_tok;
  logic [NTOK-1:0] f_mask, b_mask;
  logic            f_lossless, b_lossless;
  logic [JW-1:0]   jq_wdata, jq_rdata;
  logic            jq_empty, job_pop;
  logic            item_push, item_full;
  out_item_t       item, out_item;

  fsnd_front #(
    .BASE_LEN (BASE_LEN),
    .EXT_LEN  (EXT_LEN),
    .NTOK     (NTOK)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .base_bytes   (in_base_bytes),
    .ext_bytes    (in_ext_bytes),
    .case_flags   (in_case_flags),
    .deleted      (in_deleted),
    .job_tok      (f_tok),
    .job_mask     (f_mask),
    .job_lossless (f_lossless)
  );

  assign jq_wdata = {f_lossless, f_mask, f_tok};

  fsnd_fifo #(
    .WIDTH (JW),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (jq_wdata),
    .full    (full),
    .rd_en   (job_pop),
    .rd_data (jq_rdata),
    .empty   (jq_empty)
  );

  assign {b_lossless, b_mask, b_tok} = jq_rdata;

  fsnd_back #(
    .NTOK (NTOK)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (!jq_empty),
    .job_tok      (b_tok),
    .job_mask     (b_mask),
    .job_lossless (b_lossless),
    .job_pop      (job_pop),
    .item_full    (item_full),
    .item_push    (item_push),
    .item         (item)
  );

  fsnd_fifo #(
    .WIDTH (IW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (item_push),
    .wr_data (item),
    .full    (item_full),
    .rd_en   (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

  assign out_byte     = out_item.byte_val;
  assign out_has_byte = out_item.has_byte;
  assign out_last     = out_item.last;
  assign out_lossless = out_item.lossless;

endmodule
